// ===== hw/rtl/bldq_pkg.sv =====
`timescale 1ns / 1ps

package bldq_pkg;

   localparam int VALUE_W    = 32;
   localparam int REQ_TYPE_W = 3;
   localparam int STATUS_W   = 2;
   localparam int POSITION_W = 4;
   localparam int COUNT_W    = 5;

   typedef logic signed [VALUE_W-1:0] value_type;

   localparam logic [REQ_TYPE_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] OP_FIND       = 3'd4;
   localparam logic [REQ_TYPE_W-1:0] OP_REMOVE_ALL = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      value_type             value;
   } bldq_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic                  found;
      logic [POSITION_W-1:0] position;
      logic [COUNT_W-1:0]    removed_count;
      value_type             head_value;
      value_type             tail_value;
      logic [COUNT_W-1:0]    count;
      logic                  empty_res;
   } bldq_rsp_type;

   typedef struct packed {
      logic shift_left;
      logic shift_right;
      logic load;
   } cell_ctl_type;

endpackage

// ===== hw/rtl/bounded_list_deque_engine_core.sv =====
`timescale 1ns / 1ps

// Channel | Ports                        | Beat taken when
// --------+------------------------------+------------------------
// request | start, busy, req_data        | start high, busy low
// result  | rsp_strobe, rsp_data         | rsp_strobe high (one cycle)
//
// Most requests: result beat in the cycle after accept; the next request is accepted once busy has dropped.
// Non-empty pop back, find and remove all: the cell row rotates once through
// every entry, one per cycle, before the result beat; no new request is taken
// until busy drops after the result beat.
// Reset empties the store; entries are not cleared.
// The result beat cannot be stalled; busy stays high until it has gone out.

module bounded_list_deque_engine_core #(
   parameter int CAPACITY = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  bldq_pkg::bldq_req_type  req_data,
   output logic                    rsp_strobe,
   output bldq_pkg::bldq_rsp_type  rsp_data
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int POS_W = bldq_pkg::POSITION_W;
   localparam int FLD_W = bldq_pkg::COUNT_W;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);
   localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PASS,
      ST_REPORT
   } state_type;

   state_type                      state_ff, state_in;
   logic [CNT_W-1:0]               occ_ff, occ_in;
   logic [CNT_W-1:0]               rem_ff, rem_in;
   logic [IDX_W-1:0]               step_ff, step_in;
   logic [bldq_pkg::STATUS_W-1:0]  status_ff, status_in;
   logic                           found_ff, found_in;
   logic [POS_W-1:0]               pos_ff, pos_in;
   logic [CNT_W-1:0]               removed_ff, removed_in;
   logic [bldq_pkg::REQ_TYPE_W-1:0] op_ff, op_in;
   bldq_pkg::value_type            val_ff, val_in;
   bldq_pkg::value_type            tail_ff, tail_in;

   bldq_pkg::cell_ctl_type         cell_ctl;
   logic [IDX_W-1:0]               load_idx;
   bldq_pkg::value_type            bcast;
   bldq_pkg::value_type            cell_val [CAPACITY];
   bldq_pkg::value_type            head;
   logic                           hit;
   logic                           drop;
   logic                           is_full;
   logic                           is_empty;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         bldq_cell #(
            .IDX_W (IDX_W),
            .INDEX (gi)
         ) u_cell (
            .clock     (clock),
            .ctl       (cell_ctl),
            .load_idx  (load_idx),
            .load_data (bcast),
            .left_val  (cell_val[(gi == 0) ? 0 : gi - 1]),
            .right_val (cell_val[(gi == CAPACITY - 1) ? gi : gi + 1]),
            .value     (cell_val[gi])
         );
      end
   endgenerate

   assign head     = cell_val[0];
   assign hit      = (head == val_ff);
   assign is_full  = (occ_ff == FULL_CNT);
   assign is_empty = (occ_ff == '0);

   always_comb begin
      state_in   = state_ff;
      occ_in     = occ_ff;
      rem_in     = rem_ff;
      step_in    = step_ff;
      status_in  = status_ff;
      found_in   = found_ff;
      pos_in     = pos_ff;
      removed_in = removed_ff;
      op_in      = op_ff;
      val_in     = val_ff;
      tail_in    = tail_ff;
      cell_ctl   = '0;
      load_idx   = '0;
      bcast      = val_ff;
      drop       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in      = req_data.req_type;
               val_in     = req_data.value;
               status_in  = bldq_pkg::STATUS_OK;
               found_in   = 1'b0;
               pos_in     = '0;
               removed_in = '0;
               step_in    = '0;
               rem_in     = occ_ff;
               bcast      = req_data.value;
               state_in   = ST_REPORT;
               unique case (req_data.req_type)
                  bldq_pkg::OP_PUSH_FRONT: begin
                     if (is_full) begin
                        status_in = bldq_pkg::STATUS_FULL;
                     end else begin
                        cell_ctl.shift_right = 1'b1;
                        cell_ctl.load        = 1'b1;
                        load_idx             = '0;
                        occ_in               = occ_ff + ONE_CNT;
                        if (is_empty) begin
                           tail_in = req_data.value;
                        end
                     end
                  end
                  bldq_pkg::OP_PUSH_BACK: begin
                     if (is_full) begin
                        status_in = bldq_pkg::STATUS_FULL;
                     end else begin
                        cell_ctl.load = 1'b1;
                        load_idx      = occ_ff[IDX_W-1:0];
                        occ_in        = occ_ff + ONE_CNT;
                        tail_in       = req_data.value;
                     end
                  end
                  bldq_pkg::OP_POP_FRONT: begin
                     if (is_empty) begin
                        status_in = bldq_pkg::STATUS_EMPTY;
                     end else begin
                        cell_ctl.shift_left = 1'b1;
                        occ_in              = occ_ff - ONE_CNT;
                     end
                  end
                  bldq_pkg::OP_POP_BACK: begin
                     if (is_empty) begin
                        status_in = bldq_pkg::STATUS_EMPTY;
                     end else begin
                        state_in = ST_PASS;
                     end
                  end
                  bldq_pkg::OP_FIND,
                  bldq_pkg::OP_REMOVE_ALL: begin
                     if (!is_empty) begin
                        state_in = ST_PASS;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PASS: begin
            // rotate head to the back of the live list; drop it instead where required
            drop = ((op_ff == bldq_pkg::OP_REMOVE_ALL) && hit) ||
                   ((op_ff == bldq_pkg::OP_POP_BACK) && (rem_ff == ONE_CNT));
            cell_ctl.shift_left = 1'b1;
            cell_ctl.load       = !drop;
            load_idx            = IDX_W'(occ_ff - ONE_CNT);
            bcast               = head;
            if (drop) begin
               occ_in = occ_ff - ONE_CNT;
               if (op_ff == bldq_pkg::OP_REMOVE_ALL) begin
                  removed_in = removed_ff + ONE_CNT;
               end
            end else begin
               tail_in = head;
            end
            if ((op_ff == bldq_pkg::OP_FIND) && hit && !found_ff) begin
               found_in = 1'b1;
               pos_in   = POS_W'(step_ff);
            end
            step_in = step_ff + IDX_W'(1);
            rem_in  = rem_ff - ONE_CNT;
            if (rem_ff == ONE_CNT) begin
               state_in = ST_REPORT;
            end
         end
         ST_REPORT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         occ_ff     <= '0;
         rem_ff     <= '0;
         step_ff    <= '0;
         status_ff  <= bldq_pkg::STATUS_OK;
         found_ff   <= 1'b0;
         pos_ff     <= '0;
         removed_ff <= '0;
      end else begin
         state_ff   <= state_in;
         occ_ff     <= occ_in;
         rem_ff     <= rem_in;
         step_ff    <= step_in;
         status_ff  <= status_in;
         found_ff   <= found_in;
         pos_ff     <= pos_in;
         removed_ff <= removed_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      val_ff  <= val_in;
      tail_ff <= tail_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_REPORT);

   always_comb begin
      rsp_data.status        = status_ff;
      rsp_data.found         = found_ff;
      rsp_data.position      = pos_ff;
      rsp_data.removed_count = FLD_W'(removed_ff);
      rsp_data.head_value    = is_empty ? '0 : head;
      rsp_data.tail_value    = is_empty ? '0 : tail_ff;
      rsp_data.count         = FLD_W'(occ_ff);
      rsp_data.empty_res     = is_empty;
   end

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not raise busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= FULL_CNT)
      else $error("occupancy beyond capacity");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status == bldq_pkg::STATUS_FULL)) |-> is_full)
      else $error("push rejected while not full");
`endif

endmodule

// ===== hw/rtl/bldq_cell.sv =====
`timescale 1ns / 1ps

module bldq_cell #(
   parameter int IDX_W = 4,
   parameter int INDEX = 0
) (
   input  logic                      clock,
   input  bldq_pkg::cell_ctl_type    ctl,
   input  logic [IDX_W-1:0]          load_idx,
   input  bldq_pkg::value_type       load_data,
   input  bldq_pkg::value_type       left_val,
   input  bldq_pkg::value_type       right_val,
   output bldq_pkg::value_type       value
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

   bldq_pkg::value_type value_ff;
   bldq_pkg::value_type value_in;

   always_comb begin
      priority if (ctl.load && (load_idx == MY_IDX)) begin
         value_in = load_data;
      end else if (ctl.shift_left) begin
         value_in = right_val;
      end else if (ctl.shift_right) begin
         value_in = left_val;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== verif/bldq_result_checker.sv =====
`timescale 1ns / 1ps

module bldq_result_checker #(
   parameter int CAPACITY = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  bldq_pkg::bldq_req_type req_data,
   input  logic                   rsp_strobe,
   input  bldq_pkg::bldq_rsp_type rsp_data,
   output int                     errors,
   output int                     outstanding
);

   bldq_pkg::value_type    shadow_entries [CAPACITY];
   int                     shadow_fill;
   bldq_pkg::bldq_rsp_type outcome_q [$];

   function automatic bldq_pkg::bldq_rsp_type deque_outcome(bldq_pkg::bldq_req_type rq);
      bldq_pkg::bldq_rsp_type r;
      int                     w;
      r = '0;
      unique case (rq.req_type)
         bldq_pkg::OP_PUSH_FRONT: begin
            if (shadow_fill >= CAPACITY) begin
               r.status = bldq_pkg::STATUS_FULL;
            end else begin
               for (int i = shadow_fill; i > 0; i--) shadow_entries[i] = shadow_entries[i-1];
               shadow_entries[0] = rq.value;
               shadow_fill++;
            end
         end
         bldq_pkg::OP_PUSH_BACK: begin
            if (shadow_fill >= CAPACITY) begin
               r.status = bldq_pkg::STATUS_FULL;
            end else begin
               shadow_entries[shadow_fill] = rq.value;
               shadow_fill++;
            end
         end
         bldq_pkg::OP_POP_FRONT: begin
            if (shadow_fill == 0) begin
               r.status = bldq_pkg::STATUS_EMPTY;
            end else begin
               for (int i = 0; i < shadow_fill - 1; i++) shadow_entries[i] = shadow_entries[i+1];
               shadow_fill--;
            end
         end
         bldq_pkg::OP_POP_BACK: begin
            if (shadow_fill == 0) r.status = bldq_pkg::STATUS_EMPTY;
            else shadow_fill--;
         end
         bldq_pkg::OP_FIND: begin
            for (int i = 0; i < shadow_fill && !r.found; i++) begin
               if (shadow_entries[i] == rq.value) begin
                  r.found    = 1'b1;
                  r.position = bldq_pkg::POSITION_W'(i);
               end
            end
         end
         bldq_pkg::OP_REMOVE_ALL: begin
            w = 0;
            for (int i = 0; i < shadow_fill; i++) begin
               if (shadow_entries[i] == rq.value) begin
                  r.removed_count = r.removed_count + 1'b1;
               end else begin
                  shadow_entries[w] = shadow_entries[i];
                  w++;
               end
            end
            shadow_fill = w;
         end
         default: ;
      endcase
      r.count      = bldq_pkg::COUNT_W'(shadow_fill);
      r.empty_res  = (shadow_fill == 0);
      r.head_value = (shadow_fill != 0) ? shadow_entries[0] : '0;
      r.tail_value = (shadow_fill != 0) ? shadow_entries[shadow_fill-1] : '0;
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
         errors++;
         $display("%0t: %s expected %h actual %h", $time, name, want, seen);
      end
   endfunction

   always @(posedge clock) begin
      bldq_pkg::bldq_rsp_type want;
      if (reset) begin
         shadow_fill = 0;
         outcome_q.delete();
      end else begin
         if (start && !busy) outcome_q.insert(outcome_q.size(), deque_outcome(req_data));
         if (rsp_strobe) begin
            if (outcome_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result beat expected none actual %h", $time, rsp_data);
            end else begin
               want = outcome_q[0];
               outcome_q.delete(0);
               check_field("status", 32'(want.status), 32'(rsp_data.status));
               check_field("found", 32'(want.found), 32'(rsp_data.found));
               check_field("position", 32'(want.position), 32'(rsp_data.position));
               check_field("removed_count", 32'(want.removed_count),
                           32'(rsp_data.removed_count));
               check_field("head_value", want.head_value, rsp_data.head_value);
               check_field("tail_value", want.tail_value, rsp_data.tail_value);
               check_field("count", 32'(want.count), 32'(rsp_data.count));
               check_field("empty_res", 32'(want.empty_res), 32'(rsp_data.empty_res));
            end
         end
      end
      outstanding = outcome_q.size();
   end

endmodule

// ===== verif/tb_bounded_list_deque_engine_core.sv =====
`timescale 1ns / 1ps

module tb_bounded_list_deque_engine_core;

   localparam int                              CAPACITY     = 16;
   localparam int                              RANDOM_BEATS = 1350;
   localparam int                              QUIET_TAIL   = 150;
   localparam int                              CYCLE_LIMIT  = 200000;
   localparam logic [bldq_pkg::REQ_TYPE_W-1:0] OP_UNUSED_A  = 3'd6;
   localparam logic [bldq_pkg::REQ_TYPE_W-1:0] OP_UNUSED_B  = 3'd7;
   localparam bldq_pkg::value_type             VALUE_MAX    = 32'sh7FFFFFFF;
   localparam bldq_pkg::value_type             VALUE_MIN    = 32'sh80000000;

   logic                   clock    = 1'b0;
   logic                   reset    = 1'b1;
   logic                   start    = 1'b0;
   logic                   busy;
   bldq_pkg::bldq_req_type req_data = '0;
   logic                   rsp_strobe;
   bldq_pkg::bldq_rsp_type rsp_data;
   int                     errors;
   int                     outstanding;
   int                     cycles   = 0;

   always #2 clock = ~clock;

   bounded_list_deque_engine_core #(.CAPACITY(CAPACITY)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   bldq_result_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .errors      (errors),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // hold start high until the beat is taken
   task automatic send(logic [bldq_pkg::REQ_TYPE_W-1:0] op, bldq_pkg::value_type v);
      start    <= 1'b1;
      req_data <= '{req_type: op, value: v};
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_off(int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   bldq_pkg::value_type               pool [4];
   int                                sent;
   int                                seg_len;
   int                                mode;
   bit                                idling;
   int                                r;
   logic [bldq_pkg::REQ_TYPE_W-1:0]   op;
   bldq_pkg::value_type               v;

   initial begin
      sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(bldq_pkg::OP_POP_FRONT, 32'sd0);
      send(bldq_pkg::OP_POP_BACK, -32'sd1);
      send(bldq_pkg::OP_FIND, 32'sd5);
      send(bldq_pkg::OP_REMOVE_ALL, 32'sd5);
      send(OP_UNUSED_A, VALUE_MAX);
      send(OP_UNUSED_B, VALUE_MIN);
      repeat (4) send(bldq_pkg::OP_PUSH_BACK, 32'sd42);
      send(bldq_pkg::OP_REMOVE_ALL, 32'sd42);
      send(bldq_pkg::OP_PUSH_BACK, VALUE_MAX);
      send(bldq_pkg::OP_PUSH_FRONT, VALUE_MIN);
      send(bldq_pkg::OP_PUSH_BACK, 32'sd0);
      send(bldq_pkg::OP_PUSH_FRONT, -32'sd1);
      send(bldq_pkg::OP_FIND, VALUE_MIN);
      send(bldq_pkg::OP_FIND, 32'sd0);
      send(bldq_pkg::OP_FIND, 32'sd12345);
      send(bldq_pkg::OP_REMOVE_ALL, 32'sd12345);
      send(bldq_pkg::OP_POP_BACK, 32'sd0);
      send(bldq_pkg::OP_POP_FRONT, 32'sd0);
      drain();

      while (sent < RANDOM_BEATS) begin
         seg_len = $urandom_range(20, 80);
         mode    = $urandom_range(0, 2);
         idling  = ($urandom_range(0, 3) != 0) && (sent < RANDOM_BEATS - QUIET_TAIL);
         pool[0] = $urandom;
         pool[1] = $urandom;
         pool[2] = $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
         pool[3] = $urandom_range(0, 15);
         for (int k = 0; k < seg_len && sent < RANDOM_BEATS; k++) begin
            r = $urandom_range(0, 99);
            unique case (mode)
               0:       r = r;
               1:       r = (r < 45) ? r + 10 : r;
               default: r = (r < 55) ? r * 2 / 3 + 20 : r;
            endcase
            if (r < 55) op = $urandom_range(0, 1) ? bldq_pkg::OP_PUSH_FRONT
                                                  : bldq_pkg::OP_PUSH_BACK;
            else if (r < 65) op = $urandom_range(0, 1) ? bldq_pkg::OP_POP_FRONT
                                                       : bldq_pkg::OP_POP_BACK;
            else if (r < 80) op = bldq_pkg::OP_FIND;
            else if (r < 95) op = bldq_pkg::OP_REMOVE_ALL;
            else op = $urandom_range(0, 1) ? OP_UNUSED_A : OP_UNUSED_B;
            if (mode == 1 && $urandom_range(0, 99) < 40)
               op = $urandom_range(0, 1) ? bldq_pkg::OP_POP_FRONT : bldq_pkg::OP_POP_BACK;
            v = ($urandom_range(0, 99) < 75) ? pool[$urandom_range(0, 3)]
                                             : bldq_pkg::value_type'($urandom);
            if (idling && sent < RANDOM_BEATS - QUIET_TAIL && $urandom_range(0, 99) < 25)
               hold_off($urandom_range(1, 12));
            send(op, v);
            sent++;
         end
         if ($urandom_range(0, 2) == 0) drain();
      end

      drain();
      repeat (CAPACITY + 4) @(posedge clock);
      if (errors == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/bldq_pkg.sv
hw/rtl/bldq_cell.sv
hw/rtl/bounded_list_deque_engine_core.sv
verif/bldq_result_checker.sv
verif/tb_bounded_list_deque_engine_core.sv
